>>> src/slc_pkg.sv
package slc_pkg;

  localparam int unsigned DEF_IN_WIDTH      = 32;
  localparam int unsigned DEF_TABLE_BITS    = 6;
  localparam int unsigned DEF_OUT_FRAC_BITS = 16;

  localparam int unsigned LOG_FRAC   = 28;
  localparam int unsigned CONST_W    = 29;
  localparam int unsigned FRAC_W     = 32;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned OFFSET_W   = 32;
  localparam int unsigned LEVEL_W    = 32;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CONST_W-1:0]  LOG10_2_Q30  = 29'd323228497;
  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd2560;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 32'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN   = 8'd0,
    REG_OFFSET = 8'd1
  } cfg_reg_e;

  // Table point log2(1 + idx / 2^tb) in Q.28, found by repeated squaring.
  function automatic logic [LOG_FRAC:0] log2_entry(input int tb, input int idx);
    logic [63:0]       m;
    logic [LOG_FRAC:0] r;
    m = (64'd1 << 30) + (64'(idx) << (30 - tb));
    r = '0;
    if (idx >= (1 << tb)) begin
      r = (LOG_FRAC + 1)'(1) << LOG_FRAC;
    end else begin
      for (int b = 1; b <= LOG_FRAC; b++) begin
        m = (m * m) >> 30;
        if (m >= (64'd2 << 30)) begin
          m = m >> 1;
          r[LOG_FRAC - b] = 1'b1;
        end
      end
    end
    return r;
  endfunction

endpackage

>>> src/slc_norm.sv
module slc_norm #(
  parameter int unsigned IN_WIDTH   = slc_pkg::DEF_IN_WIDTH,
  parameter int unsigned TABLE_BITS = slc_pkg::DEF_TABLE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [IN_WIDTH-1:0]           sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [$clog2(IN_WIDTH)-1:0]   exp_o,
  output logic [TABLE_BITS-1:0]         idx_o,
  output logic [31-TABLE_BITS:0]        rem_o
);
  import slc_pkg::*;

  localparam int unsigned E_W   = $clog2(IN_WIDTH);
  localparam int unsigned REM_W = FRAC_W - TABLE_BITS;
  localparam int unsigned EXT_W = IN_WIDTH - 1 + FRAC_W;

  logic                  v1_q, v2_q;
  logic                  adv1, adv2;
  logic [IN_WIDTH-1:0]   x_floor;
  logic [E_W-1:0]        lead;
  logic [IN_WIDTH-1:0]   x_q;
  logic [E_W-1:0]        exp1_q;
  logic [IN_WIDTH-1:0]   norm;
  logic [EXT_W-1:0]      frac_ext;
  logic [FRAC_W-1:0]     frac32;
  logic [E_W-1:0]        exp2_q;
  logic [TABLE_BITS-1:0] idx_q;
  logic [REM_W-1:0]      rem_q;

  assign adv2       = !v2_q || !out_stall_i;
  assign adv1       = !v1_q || adv2;
  assign in_stall_o = !adv1;

  always_comb begin
    x_floor = (sample_i == '0) ? IN_WIDTH'(1) : sample_i;
    lead    = '0;
    for (int i = 0; i < IN_WIDTH; i++) begin
      if (x_floor[i]) begin
        lead = E_W'(i);
      end
    end
  end

  assign norm     = x_q << (E_W'(IN_WIDTH - 1) - exp1_q);
  assign frac_ext = {norm[IN_WIDTH-2:0], {FRAC_W{1'b0}}};
  assign frac32   = frac_ext[EXT_W-1 -: FRAC_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv1) begin
        v1_q <= in_valid_i;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      x_q    <= x_floor;
      exp1_q <= lead;
    end
    if (adv2) begin
      exp2_q <= exp1_q;
      idx_q  <= frac32[FRAC_W-1 -: TABLE_BITS];
      rem_q  <= frac32[REM_W-1:0];
    end
  end

  assign out_valid_o = v2_q;
  assign exp_o       = exp2_q;
  assign idx_o       = idx_q;
  assign rem_o       = rem_q;

endmodule

>>> src/slc_interp.sv
module slc_interp #(
  parameter int unsigned IN_WIDTH   = slc_pkg::DEF_IN_WIDTH,
  parameter int unsigned TABLE_BITS = slc_pkg::DEF_TABLE_BITS
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          in_valid_i,
  output logic                                          in_stall_o,
  input  logic [$clog2(IN_WIDTH)-1:0]                   exp_i,
  input  logic [TABLE_BITS-1:0]                         idx_i,
  input  logic [31-TABLE_BITS:0]                        rem_i,
  output logic                                          out_valid_o,
  input  logic                                          out_stall_i,
  output logic [$clog2(IN_WIDTH+1)+slc_pkg::LOG_FRAC-1:0] lg2_o
);
  import slc_pkg::*;

  localparam int unsigned E_W   = $clog2(IN_WIDTH);
  localparam int unsigned REM_W = FRAC_W - TABLE_BITS;
  localparam int unsigned TBL_N = (1 << TABLE_BITS) + 1;
  localparam int unsigned LG2_W = $clog2(IN_WIDTH + 1) + LOG_FRAC;
  localparam int unsigned MUL_W = LOG_FRAC + REM_W;

  logic [LOG_FRAC:0]     log_rom [TBL_N];
  logic                  v3_q, v4_q, v5_q;
  logic                  adv3, adv4, adv5;
  logic [TABLE_BITS:0]   idx_lo, idx_hi;
  logic [LOG_FRAC:0]     lo, hi;
  logic [LOG_FRAC-1:0]   diff;
  logic [LOG_FRAC:0]     lo3_q, lo4_q;
  logic [LOG_FRAC-1:0]   diff3_q;
  logic [REM_W-1:0]      rem3_q;
  logic [E_W-1:0]        exp3_q, exp4_q;
  logic [MUL_W-1:0]      mul;
  logic [MUL_W-1:0]      mul4_q;
  logic [LG2_W-1:0]      lg2_d, lg2_q;

  for (genvar g = 0; g < TBL_N; g++) begin : g_rom
    localparam logic [LOG_FRAC:0] Entry = log2_entry(TABLE_BITS, g);
    assign log_rom[g] = Entry;
  end

  assign adv5       = !v5_q || !out_stall_i;
  assign adv4       = !v4_q || adv5;
  assign adv3       = !v3_q || adv4;
  assign in_stall_o = !adv3;

  assign idx_lo = {1'b0, idx_i};
  assign idx_hi = idx_lo + (TABLE_BITS + 1)'(1);
  assign lo     = log_rom[idx_lo];
  assign hi     = log_rom[idx_hi];
  assign diff   = LOG_FRAC'(hi - lo);

  assign mul = MUL_W'(diff3_q) * MUL_W'(rem3_q);

  assign lg2_d = LG2_W'({exp4_q, {LOG_FRAC{1'b0}}}) + LG2_W'(lo4_q)
               + LG2_W'(mul4_q[MUL_W-1:REM_W]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (adv3) begin
        v3_q <= in_valid_i;
      end
      if (adv4) begin
        v4_q <= v3_q;
      end
      if (adv5) begin
        v5_q <= v4_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      lo3_q   <= lo;
      diff3_q <= diff;
      rem3_q  <= rem_i;
      exp3_q  <= exp_i;
    end
    if (adv4) begin
      mul4_q <= mul;
      lo4_q  <= lo3_q;
      exp4_q <= exp3_q;
    end
    if (adv5) begin
      lg2_q <= lg2_d;
    end
  end

  assign out_valid_o = v5_q;
  assign lg2_o       = lg2_q;

endmodule

>>> src/slc_scale.sv
module slc_scale #(
  parameter int unsigned IN_WIDTH      = slc_pkg::DEF_IN_WIDTH,
  parameter int unsigned OUT_FRAC_BITS = slc_pkg::DEF_OUT_FRAC_BITS
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          in_valid_i,
  output logic                                          in_stall_o,
  input  logic [$clog2(IN_WIDTH+1)+slc_pkg::LOG_FRAC-1:0] lg2_i,
  input  logic [slc_pkg::GAIN_W-1:0]                    gain_i,
  input  logic [slc_pkg::OFFSET_W-1:0]                  offset_i,
  output logic                                          out_valid_o,
  input  logic                                          out_stall_i,
  output logic [slc_pkg::LEVEL_W-1:0]                   level_o
);
  import slc_pkg::*;

  localparam int unsigned LG2_W  = $clog2(IN_WIDTH + 1) + LOG_FRAC;
  localparam int unsigned LG10_W = LG2_W + 1;
  localparam int unsigned P1_W   = LG2_W + CONST_W;
  localparam int unsigned PROD_W = LG10_W + GAIN_W;
  localparam int unsigned SHIFT  = 38 - OUT_FRAC_BITS;
  localparam int unsigned RND_W  = PROD_W + 1 - SHIFT;
  localparam int unsigned SUM_W  = ((RND_W > LEVEL_W) ? RND_W : LEVEL_W) + 2;

  localparam logic [PROD_W:0] Half = (PROD_W + 1)'(1) << (SHIFT - 1);
  localparam logic signed [SUM_W-1:0] SatMax =
    {{(SUM_W - LEVEL_W + 1){1'b0}}, {(LEVEL_W - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SatMin =
    {{(SUM_W - LEVEL_W + 1){1'b1}}, {(LEVEL_W - 1){1'b0}}};

  logic                     v6_q, v7_q, v8_q;
  logic                     adv6, adv7, adv8;
  logic [P1_W-1:0]          p1;
  logic [LG10_W-1:0]        lg10_q;
  logic [GAIN_W-1:0]        mag;
  logic [PROD_W-1:0]        prod;
  logic [PROD_W-1:0]        prod7_q;
  logic                     neg7_q;
  logic [PROD_W:0]          rsum;
  logic signed [SUM_W-1:0]  rnd_mag;
  logic signed [SUM_W-1:0]  rnd_signed;
  logic signed [SUM_W-1:0]  off_ext;
  logic signed [SUM_W-1:0]  total;
  logic [LEVEL_W-1:0]       level_d, level_q;

  assign adv8       = !v8_q || !out_stall_i;
  assign adv7       = !v7_q || adv8;
  assign adv6       = !v6_q || adv7;
  assign in_stall_o = !adv6;

  assign p1 = P1_W'(lg2_i) * P1_W'(LOG10_2_Q30);

  assign mag  = gain_i[GAIN_W-1] ? GAIN_W'(-gain_i) : gain_i;
  assign prod = PROD_W'(lg10_q) * PROD_W'(mag);

  always_comb begin
    rsum       = {1'b0, prod7_q} + Half;
    rnd_mag    = SUM_W'(rsum[PROD_W:SHIFT]);
    rnd_signed = neg7_q ? -rnd_mag : rnd_mag;
    off_ext    = {{(SUM_W - OFFSET_W){offset_i[OFFSET_W-1]}}, offset_i};
    total      = rnd_signed + off_ext;
    if (total > SatMax) begin
      level_d = SatMax[LEVEL_W-1:0];
    end else if (total < SatMin) begin
      level_d = SatMin[LEVEL_W-1:0];
    end else begin
      level_d = total[LEVEL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else begin
      if (adv6) begin
        v6_q <= in_valid_i;
      end
      if (adv7) begin
        v7_q <= v6_q;
      end
      if (adv8) begin
        v8_q <= v7_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv6) begin
      lg10_q <= p1[P1_W-1:LOG_FRAC];
    end
    if (adv7) begin
      prod7_q <= prod;
      neg7_q  <= gain_i[GAIN_W-1];
    end
    if (adv8) begin
      level_q <= level_d;
    end
  end

  assign out_valid_o = v8_q;
  assign level_o     = level_q;

endmodule

>>> src/scaled_log10_converter.sv
// Scaled log10 converter: level_out = gain * log10(sample_in) + offset.
// Input channel: sample_in_i with in_valid_i; the block drives in_stall_o.
// A beat is taken at a rising edge with in_valid_i high and in_stall_o low.
// Output channel: level_out_o with out_valid_o; the receiver drives
// out_stall_i, and a beat leaves when out_valid_o is high and out_stall_i low.
// The result is signed with OUT_FRAC_BITS fraction bits and saturates at the
// 32-bit range. A zero sample is taken as one, so it returns the offset.
// The path from input beat to output valid runs through eight register
// stages: leading-one search, normalizing shift, table read, interpolation
// multiply, log2 sum, log10(2) multiply, gain multiply, round/offset/clamp.
// Throughput is one beat per cycle while in_stall_o is low. A stalled
// output holds its beat, and stages that hold a bubble keep filling, so
// in_stall_o rises only once every stage holds a beat.
// Configuration beats (cfg_valid_i, cfg_ready_o always high) write gain at
// index 0 and offset at index 1; other indexes are ignored. They are meant to
// be written while no beat is in flight.
// Reset empties the pipeline and sets gain to 10.0 and offset to 0.
module scaled_log10_converter #(
  parameter int unsigned IN_WIDTH      = slc_pkg::DEF_IN_WIDTH,
  parameter int unsigned TABLE_BITS    = slc_pkg::DEF_TABLE_BITS,
  parameter int unsigned OUT_FRAC_BITS = slc_pkg::DEF_OUT_FRAC_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [IN_WIDTH-1:0]              sample_in_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [slc_pkg::LEVEL_W-1:0]      level_out_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [slc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [slc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import slc_pkg::*;

  localparam int unsigned E_W   = $clog2(IN_WIDTH);
  localparam int unsigned REM_W = FRAC_W - TABLE_BITS;
  localparam int unsigned LG2_W = $clog2(IN_WIDTH + 1) + LOG_FRAC;

  logic [GAIN_W-1:0]     gain_d, gain_q;
  logic [OFFSET_W-1:0]   offset_d, offset_q;
  logic                  norm_valid, norm_stall;
  logic                  interp_valid, interp_stall;
  logic [E_W-1:0]        norm_exp;
  logic [TABLE_BITS-1:0] norm_idx;
  logic [REM_W-1:0]      norm_rem;
  logic [LG2_W-1:0]      lg2;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    gain_d   = gain_q;
    offset_d = offset_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_GAIN: begin
          gain_d = cfg_data_i[GAIN_W-1:0];
        end
        REG_OFFSET: begin
          offset_d = cfg_data_i[OFFSET_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= GAIN_RESET;
      offset_q <= OFFSET_RESET;
    end else begin
      gain_q   <= gain_d;
      offset_q <= offset_d;
    end
  end

  slc_norm #(
    .IN_WIDTH   (IN_WIDTH),
    .TABLE_BITS (TABLE_BITS)
  ) u_norm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_in_i),
    .out_valid_o (norm_valid),
    .out_stall_i (norm_stall),
    .exp_o       (norm_exp),
    .idx_o       (norm_idx),
    .rem_o       (norm_rem)
  );

  slc_interp #(
    .IN_WIDTH   (IN_WIDTH),
    .TABLE_BITS (TABLE_BITS)
  ) u_interp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (norm_valid),
    .in_stall_o  (norm_stall),
    .exp_i       (norm_exp),
    .idx_i       (norm_idx),
    .rem_i       (norm_rem),
    .out_valid_o (interp_valid),
    .out_stall_i (interp_stall),
    .lg2_o       (lg2)
  );

  slc_scale #(
    .IN_WIDTH      (IN_WIDTH),
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (interp_valid),
    .in_stall_o  (interp_stall),
    .lg2_i       (lg2),
    .gain_i      (gain_q),
    .offset_i    (offset_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .level_o     (level_out_o)
  );

  // The input only stalls when the whole pipeline is backed up behind the output.
  a_stall_only_when_full : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && interp_stall && norm_stall)
  ) else $error("input stalled while the pipeline has room");

  a_gain_write : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o && (cfg_index_i == REG_GAIN))
      |=> (gain_q == $past(cfg_data_i[GAIN_W-1:0]))
  ) else $error("gain write not taken");

  a_offset_write : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o && (cfg_index_i == REG_OFFSET))
      |=> (offset_q == $past(cfg_data_i[OFFSET_W-1:0]))
  ) else $error("offset write not taken");

endmodule
